[hdl/ucfr_pkg.sv]
// Shared constants and types for the command frame receiver.
`default_nettype none

package ucfr_pkg;

    // Byte codes that mark the header and the terminator.
    localparam logic [7:0] HDR_FIRST  = 8'h7F;
    localparam logic [7:0] HDR_SECOND = 8'h25;
    localparam logic [7:0] TERM_CR    = 8'h0D;
    localparam logic [7:0] TERM_LF    = 8'h0A;

    // Width of the reported command length.
    localparam int CMD_LEN_W = 6;

    // Emitter states.
    typedef enum logic [0:0] {
        BK_IDLE,
        BK_EMIT
    } bk_state_t;

    // Status that the emitter reports to the top level.
    typedef struct packed {
        logic busy;
        logic release_bank;
    } bk_status_t;

endpackage

`default_nettype wire

[hdl/uart_command_frame_receiver.sv]
// Top level of the command frame receiver: intake, descriptor queue and emitter.
//
// Input channel (in_valid/in_ready) takes one received byte per beat with the
// port it came from. A 0x7F 0x25 pair restarts the frame with that header;
// a CR LF pair ends a command. Bytes are written into one of two store banks.
// Output channel (out_valid/out_ready) gives one beat per stored byte before
// the CR, with the length, the port of the LF and a last flag; an empty
// command gives a single beat marked empty.
// The first beat of a command is registered after the LF is accepted, once its
// descriptor has passed the queue and the emitter state; further beats follow
// one per cycle while out_ready is high.
// Throughput: one input byte per cycle while fewer than two commands are
// pending; with both banks waiting to be played out, in_ready drops until
// the emitter has read the last byte of the older one.
// Reset clears the fill position, the queue and the output valid; the store
// needs no clearing. A stalled receiver holds the current output beat and
// the emitter; the intake runs on until both banks are taken.
`default_nettype none

module uart_command_frame_receiver
    import ucfr_pkg::*;
#(
    parameter int FILL_LIMIT = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 source_port,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                cmd_byte,
    output logic [CMD_LEN_W-1:0]      cmd_length,
    output logic                      out_port,
    output logic                      is_empty,
    output logic                      last
);

    localparam int LEN_W  = $clog2(FILL_LIMIT);
    localparam int DESC_W = LEN_W + 4;

    logic              desc_push;
    logic [DESC_W-1:0] desc_data;
    logic              q_valid;
    logic [DESC_W-1:0] q_data;
    logic [1:0]        q_count;
    logic              q_pop;
    logic              wr_en;
    logic              wr_bank;
    logic [LEN_W-1:0]  wr_pos;
    logic [7:0]        wr_data;
    bk_status_t        bk_status;

    ucfr_front #(
        .FILL_LIMIT(FILL_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .source_port (source_port),
        .release_bank(bk_status.release_bank),
        .desc_push   (desc_push),
        .desc_data   (desc_data),
        .wr_en       (wr_en),
        .wr_bank     (wr_bank),
        .wr_pos      (wr_pos),
        .wr_data     (wr_data)
    );

    ucfr_desc_fifo #(
        .DATA_W(DESC_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (desc_push),
        .push_data(desc_data),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_count  (q_count)
    );

    ucfr_back #(
        .FILL_LIMIT(FILL_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_pos    (wr_pos),
        .wr_data   (wr_data),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .status    (bk_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd_byte  (cmd_byte),
        .cmd_length(cmd_length),
        .out_port  (out_port),
        .is_empty  (is_empty),
        .last      (last)
    );

    // The queue never receives a descriptor while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> (q_count != 2'd2))
        else $error("descriptor pushed into a full queue");

    // Intake stalls only while commands are pending downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (q_count != 2'd0 || bk_status.busy))
        else $error("intake stalled with nothing pending");

    // An empty command is always a single beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> last)
        else $error("empty command beat without last");

    // A bank is released only by a busy emitter.
    assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.release_bank |-> bk_status.busy)
        else $error("bank released while emitter idle");

endmodule

`default_nettype wire

[hdl/ucfr_front.sv]
// Byte intake: tracks the fill position, spots header and terminator pairs, writes the store.
`default_nettype none

module ucfr_front
    import ucfr_pkg::*;
#(
    parameter int FILL_LIMIT = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic [7:0]                                rx_byte,
    input  wire logic                                      source_port,
    input  wire logic                                      release_bank,
    output logic                                           desc_push,
    output logic [$bits(logic [$clog2(FILL_LIMIT)-1:0]) + 3:0] desc_data,
    output logic                                           wr_en,
    output logic                                           wr_bank,
    output logic [$clog2(FILL_LIMIT)-1:0]                  wr_pos,
    output logic [7:0]                                     wr_data
);

    localparam int POS_W = $clog2(FILL_LIMIT + 1);
    localparam int LEN_W = $clog2(FILL_LIMIT);

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             port;
        logic             empty;
        logic             hdr;
    } desc_t;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       prev_reg;
    logic             hdr_flag_reg, hdr_flag_next;
    logic             bank_reg;
    logic [1:0]       outst_reg, outst_next;
    logic             accept;
    logic             pos_nz;
    logic             at_limit;
    logic             is_hdr;
    logic             is_term;
    desc_t            desc;

    // Two banks; a third command would overwrite one still being read.
    assign in_ready = (outst_reg < 2'd2);
    assign accept   = in_valid && in_ready;

    // Pair detection against the byte stored just before this one.
    assign pos_nz   = (pos_reg != '0);
    assign at_limit = (pos_reg == POS_W'(FILL_LIMIT));
    assign is_hdr   = pos_nz && (prev_reg == HDR_FIRST) && (rx_byte == HDR_SECOND);
    assign is_term  = !is_hdr && pos_nz && (prev_reg == TERM_CR) && (rx_byte == TERM_LF);

    // Store write: a header only rewrites position one, position zero reads via the flag.
    always_comb
    begin
        wr_bank = bank_reg;
        wr_pos  = LEN_W'(pos_reg);
        wr_data = rx_byte;
        wr_en   = accept && !at_limit;
        if (is_hdr)
        begin
            wr_pos  = LEN_W'(1);
            wr_data = HDR_SECOND;
            wr_en   = accept;
        end
    end

    // Command descriptor for the emitter.
    always_comb
    begin
        desc.bank  = bank_reg;
        desc.len   = LEN_W'(pos_reg - POS_W'(1));
        desc.port  = source_port;
        desc.empty = (pos_reg == POS_W'(1));
        desc.hdr   = hdr_flag_reg;
    end

    assign desc_push = accept && is_term;
    assign desc_data = desc;

    // Next fill position and header flag.
    always_comb
    begin
        if (is_hdr)
            pos_next = POS_W'(2);
        else if (is_term || at_limit)
            pos_next = '0;
        else
            pos_next = pos_reg + POS_W'(1);

        if (is_hdr)
            hdr_flag_next = 1'b1;
        else if (!pos_nz)
            hdr_flag_next = 1'b0;
        else
            hdr_flag_next = hdr_flag_reg;
    end

    // Banks handed to the emitter and not yet released.
    always_comb
    begin
        outst_next = outst_reg;
        if (desc_push && !release_bank)
            outst_next = outst_reg + 2'd1;
        else if (!desc_push && release_bank)
            outst_next = outst_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_flag_reg <= 1'b0;
            bank_reg     <= 1'b0;
            outst_reg    <= 2'd0;
        end
        else
        begin
            outst_reg <= outst_next;
            if (accept)
            begin
                pos_reg      <= pos_next;
                hdr_flag_reg <= hdr_flag_next;
                if (is_term)
                    bank_reg <= ~bank_reg;
            end
        end
    end

    // Previous byte is only consulted when the fill position is nonzero.
    always_ff @(posedge clk)
    begin
        if (accept)
            prev_reg <= rx_byte;
    end

endmodule

`default_nettype wire

[hdl/ucfr_desc_fifo.sv]
// Two-entry queue of command descriptors between intake and emitter.
`default_nettype none

module ucfr_desc_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic                   q_valid,
    output logic [DATA_W-1:0]      q_data,
    output logic [1:0]             q_count
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;

    assign q_valid = (count_reg != 2'd0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign q_count = count_reg;

    // Occupancy update.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[hdl/ucfr_back.sv]
// Emitter: two-bank frame store; plays commands out one beat per cycle while out_ready is high.
`default_nettype none

module ucfr_back
    import ucfr_pkg::*;
#(
    parameter int FILL_LIMIT = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      wr_en,
    input  wire logic                                      wr_bank,
    input  wire logic [$clog2(FILL_LIMIT)-1:0]             wr_pos,
    input  wire logic [7:0]                                wr_data,
    input  wire logic                                      q_valid,
    input  wire logic [$bits(logic [$clog2(FILL_LIMIT)-1:0]) + 3:0] q_data,
    output logic                                           q_pop,
    output bk_status_t                                     status,
    output logic                                           out_valid,
    input  wire logic                                      out_ready,
    output logic [7:0]                                     cmd_byte,
    output logic [CMD_LEN_W-1:0]                           cmd_length,
    output logic                                           out_port,
    output logic                                           is_empty,
    output logic                                           last
);

    localparam int LEN_W  = $clog2(FILL_LIMIT);
    localparam int ADDR_W = $clog2(2 * FILL_LIMIT);
    localparam int DEPTH  = 2 * FILL_LIMIT;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             port;
        logic             empty;
        logic             hdr;
    } desc_t;

    logic [7:0]           frame_mem [DEPTH];
    bk_state_t            state_reg, state_next;
    desc_t                desc_reg;
    desc_t                q_desc;
    logic [LEN_W-1:0]     idx_reg;
    logic                 issue;
    logic                 cur_last;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 out_valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 sub_reg;
    logic                 empty_reg;
    logic                 last_reg;
    logic [CMD_LEN_W-1:0] len_out_reg;
    logic                 port_reg;

    assign q_desc = q_data;

    // Bank one sits above bank zero.
    assign wr_addr = wr_bank ? (ADDR_W'(FILL_LIMIT) + ADDR_W'(wr_pos)) : ADDR_W'(wr_pos);
    assign rd_addr = desc_reg.bank ? (ADDR_W'(FILL_LIMIT) + ADDR_W'(idx_reg))
                                   : ADDR_W'(idx_reg);

    assign cur_last = desc_reg.empty || (idx_reg == (desc_reg.len - LEN_W'(1)));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (issue && cur_last)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // State outputs: take a descriptor when idle, read one byte whenever the output slot frees.
    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                q_pop = q_valid;
            BK_EMIT:
                issue = !out_valid_reg || out_ready;
            default:
            begin
                q_pop = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    // The bank is free once its last byte has been read.
    assign status.busy         = (state_reg == BK_EMIT);
    assign status.release_bank = issue && cur_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (issue)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Descriptor and byte index.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_desc;
            idx_reg  <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + LEN_W'(1);
        end
    end

    // Frame store write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= wr_data;
    end

    // Registered read, which is also the output register.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= frame_mem[rd_addr];
            sub_reg     <= desc_reg.hdr && (idx_reg == '0);
            empty_reg   <= desc_reg.empty;
            last_reg    <= cur_last;
            len_out_reg <= CMD_LEN_W'(desc_reg.len);
            port_reg    <= desc_reg.port;
        end
    end

    // Position zero after a header reads as the header byte; an empty command shows zero.
    always_comb
    begin
        if (empty_reg)
            cmd_byte = 8'h00;
        else if (sub_reg)
            cmd_byte = HDR_FIRST;
        else
            cmd_byte = rd_data_reg;
    end

    assign out_valid  = out_valid_reg;
    assign cmd_length = len_out_reg;
    assign out_port   = port_reg;
    assign is_empty   = empty_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

[tb/sv/tb_uart_command_frame_receiver.sv]
// Self-checking testbench for the command frame receiver.
`default_nettype none

module tb_uart_command_frame_receiver;
    import ucfr_pkg::*;

    localparam int FILL_LIMIT  = 64;
    localparam int HOLD_CYCLES = 300;

    // One byte waiting to be offered on the input channel.
    typedef struct packed {
        logic [7:0] value;
        logic       port;
    } rx_item_t;

    // One output beat that the frame model predicts.
    typedef struct packed {
        logic [7:0]           data;
        logic [CMD_LEN_W-1:0] len;
        logic                 port;
        logic                 empty;
        logic                 fin;
    } cmd_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           rx_byte = 8'h00;
    logic                 source_port = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           cmd_byte;
    logic [CMD_LEN_W-1:0] cmd_length;
    logic                 out_port;
    logic                 is_empty;
    logic                 last;

    rx_item_t  byte_q[$];
    cmd_beat_t cmd_beats[$];
    cmd_beat_t head_beat;

    // Shadow copy of the frame buffer and its fill position.
    logic [7:0] frame_mem [0:FILL_LIMIT];
    logic [6:0] fill_pos = '0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    logic hold_req = 1'b0;
    int  error_count = 0;
    int  bytes_queued = 0;
    int  beats_checked = 0;
    int  commands_seen = 0;

    // Directed opening bytes and the idling mix of each random phase.
    logic [7:0] opening [24] = '{
        TERM_CR, TERM_LF,                         // empty command
        TERM_LF,                                  // LF with no byte before it
        TERM_CR, TERM_LF,
        HDR_FIRST, TERM_CR, TERM_LF,
        HDR_SECOND, 8'h00, 8'hFF, TERM_CR, TERM_LF,
        8'h11, HDR_FIRST, HDR_SECOND, 8'h80, TERM_CR, TERM_LF,
        HDR_FIRST, HDR_FIRST, HDR_SECOND, TERM_CR, TERM_LF
    };
    int send_idle_set [4] = '{0, 52, 0, 8};
    int stall_set [4]     = '{0, 0, 52, 8};

    uart_command_frame_receiver #(
        .FILL_LIMIT(FILL_LIMIT)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .source_port(source_port),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd_byte   (cmd_byte),
        .cmd_length (cmd_length),
        .out_port   (out_port),
        .is_empty   (is_empty),
        .last       (last)
    );

    always #10 clk = ~clk;

    // Store one accepted byte in the shadow frame and queue the beats of any
    // command that it completes.
    task automatic absorb_byte(input logic [7:0] value, input logic port);
        int        pos;
        int        count;
        int        i;
        cmd_beat_t beat;
        pos = fill_pos;
        if (pos > FILL_LIMIT)
        begin
            pos = 0;
        end
        frame_mem[pos] = value;

        // A header pair restarts the frame with just the header.
        if (pos > 0 && frame_mem[pos - 1] == HDR_FIRST && value == HDR_SECOND)
        begin
            frame_mem[0] = HDR_FIRST;
            frame_mem[1] = HDR_SECOND;
            pos = 1;
        end

        if (pos > 0 && frame_mem[pos - 1] == TERM_CR && frame_mem[pos] == TERM_LF)
        begin
            count = pos - 1;
            beat.port = port;
            if (count == 0)
            begin
                beat.data  = 8'h00;
                beat.len   = '0;
                beat.empty = 1'b1;
                beat.fin   = 1'b1;
                cmd_beats.push_back(beat);
            end
            else
            begin
                for (i = 0; i < count; i++)
                begin
                    beat.data  = frame_mem[i];
                    beat.len   = count[CMD_LEN_W-1:0];
                    beat.empty = 1'b0;
                    beat.fin   = (i + 1 == count);
                    cmd_beats.push_back(beat);
                end
            end
            pos = 0;
        end
        else if (pos < FILL_LIMIT)
        begin
            pos++;
        end
        else
        begin
            // Overflow drops everything stored so far.
            pos = 0;
        end
        fill_pos = pos[6:0];
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic port);
        rx_item_t item;
        item.value = value;
        item.port  = port;
        byte_q.push_back(item);
        bytes_queued++;
    endtask

    // A byte that can neither start a header nor a terminator.
    function automatic logic [7:0] plain_byte();
        logic [7:0] value;
        value = 8'($urandom_range(255));
        if (value == TERM_CR || value == HDR_FIRST)
        begin
            value = value ^ 8'h01;
        end
        return value;
    endfunction

    // Header, payload and CR LF; a plain payload keeps the length exact.
    task automatic queue_framed_command(input int payload, input bit plain);
        int i;
        queue_byte(HDR_FIRST, 1'($urandom_range(1)));
        queue_byte(HDR_SECOND, 1'($urandom_range(1)));
        for (i = 0; i < payload; i++)
        begin
            queue_byte(plain ? plain_byte() : 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        end
        queue_byte(TERM_CR, 1'($urandom_range(1)));
        queue_byte(TERM_LF, 1'($urandom_range(1)));
    endtask

    // Mostly well-formed commands, with bare commands and stray bytes mixed in.
    task automatic queue_random_traffic(input int target);
        int         stop_at;
        int         kind;
        int         i;
        logic [7:0] pick;
        stop_at = bytes_queued + target;
        while (bytes_queued < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 65)
            begin
                queue_framed_command($urandom_range(4), 1'b0);
            end
            else if (kind < 80)
            begin
                for (i = $urandom_range(5); i > 0; i--)
                begin
                    queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                queue_byte(TERM_CR, 1'($urandom_range(1)));
                queue_byte(TERM_LF, 1'($urandom_range(1)));
            end
            else
            begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                begin
                    case ($urandom_range(4))
                        0: pick = TERM_CR;
                        1: pick = TERM_LF;
                        2: pick = HDR_FIRST;
                        3: pick = HDR_SECOND;
                        default: pick = 8'($urandom_range(255));
                    endcase
                    queue_byte(pick, 1'($urandom_range(1)));
                end
            end
        end
    endtask

    // Block until every queued byte went in and every predicted beat came out.
    task wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (byte_q.size() != 0 || in_valid || cmd_beats.size() != 0);
    endtask

    // Input driver: offers the next queued byte once the current beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            rx_byte     <= 8'h00;
            source_port <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid    <= 1'b1;
                rx_byte     <= byte_q[0].value;
                source_port <= byte_q[0].port;
                void'(byte_q.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down in its own process.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Output monitor: checks taken beats first, then predicts from the input
    // beat of the same edge, so an early output beat cannot match it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (cmd_beats.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected beat, expected none, got byte %02h len %0d",
                             $time, cmd_byte, cmd_length);
                end
                else
                begin
                    head_beat = cmd_beats.pop_front();
                    // The byte carries no meaning on an empty command.
                    if (!head_beat.empty && cmd_byte !== head_beat.data)
                    begin
                        error_count++;
                        $display("%0t: cmd_byte expected %02h, got %02h",
                                 $time, head_beat.data, cmd_byte);
                    end
                    if (cmd_length !== head_beat.len)
                    begin
                        error_count++;
                        $display("%0t: cmd_length expected %0d, got %0d",
                                 $time, head_beat.len, cmd_length);
                    end
                    if (out_port !== head_beat.port)
                    begin
                        error_count++;
                        $display("%0t: out_port expected %0d, got %0d",
                                 $time, head_beat.port, out_port);
                    end
                    if (is_empty !== head_beat.empty)
                    begin
                        error_count++;
                        $display("%0t: is_empty expected %0d, got %0d",
                                 $time, head_beat.empty, is_empty);
                    end
                    if (last !== head_beat.fin)
                    begin
                        error_count++;
                        $display("%0t: last expected %0d, got %0d",
                                 $time, head_beat.fin, last);
                    end
                    if (head_beat.fin)
                    begin
                        commands_seen++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                absorb_byte(rx_byte, source_port);
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus sequence, phase by phase.
    initial
    begin
        int i;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases around the start of the buffer and the pairs.
        for (i = 0; i < 24; i++)
        begin
            queue_byte(opening[i], i[0]);
        end
        wait_drained();

        // A run one byte past the buffer limit is dropped, so the CR LF after
        // it comes out as an empty command.
        for (i = 0; i <= FILL_LIMIT; i++)
        begin
            queue_byte(plain_byte(), 1'($urandom_range(1)));
        end
        queue_byte(TERM_CR, 1'b1);
        queue_byte(TERM_LF, 1'b0);
        wait_drained();

        // Random traffic under each idling mix; the sender waits in between.
        for (i = 0; i < 4; i++)
        begin
            send_idle_pct  = send_idle_set[i];
            recv_stall_pct = stall_set[i];
            queue_random_traffic(3);
            wait_drained();
        end

        // Hold the receiver off while short commands keep arriving.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            queue_framed_command($urandom_range(1, 2), 1'b0);
        end
        wait_drained();

        repeat (FILL_LIMIT + 8) @(negedge clk);
        $display("Sent %0d bytes; checked %0d beats over %0d commands.",
                 bytes_queued, beats_checked, commands_seen);
        $display("Phases: directed pairs, an overflowing run, four idle mixes, hold-off.");
        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
